### rtl/core/flux_code_to_mfm_expander_assert.svh
// Assertion macros shared by the expander RTL.
`ifndef FLUX_CODE_TO_MFM_EXPANDER_ASSERT_SVH
`define FLUX_CODE_TO_MFM_EXPANDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FC2MFM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fc2mfm: same-cycle check failed");
`define FC2MFM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fc2mfm: next-cycle check failed");
`else
`define FC2MFM_ASSERT_IMP(label, clk, rst, ante, cons)
`define FC2MFM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/fc2mfm_pkg.sv
package fc2mfm_pkg;

   localparam int CodeWidth  = 8;
   localparam int CountWidth = 14;

   // Interval code that ends the track.
   localparam logic [1:0] CODE_END = 2'd0;

   localparam logic [CountWidth-1:0] LIMIT_RESET = 14'd13888;

   typedef struct packed {
      logic [CountWidth-1:0] byte_count;
      logic                  track_done;
      logic                  last_of_item;
      logic                  byte_valid;
      logic [7:0]            data_byte;
   } rsp_type;

endpackage

### rtl/core/flux_code_to_mfm_expander.sv
// Channel  | Beat fields                                   | Direction
// req_     | tdata: code_byte; tuser: first_of_track;     | in
//          | tlast: last_of_input                          |
// rsp_     | tdata: data_byte, byte_count; tuser:          | out
//          | byte_valid, track_done; tlast: last_of_item   |
// csr_     | wr_data: output_limit                         | in
//
// An accepted beat is held in an input register; the whole expansion of its four
// codes is computed combinationally from there and written into a two-entry result buffer.
// A beat with one or no result moves on every cycle while the result port accepts; a beat
// with two results holds off the next beat while the single result port drains the buffer.
// An accepted beat passes the input register and then the result buffer before its first result shows.
// Synchronous reset clears the track state and sets the limit to 13888.
// A stalled result port holds the input register, which then holds req_tready low.
`include "flux_code_to_mfm_expander_assert.svh"

module flux_code_to_mfm_expander (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] code_byte
   input  logic        req_tuser,   // [0] first_of_track
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [21:8] byte_count, [23:22] zero
   output logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] track_done
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [13:0] csr_wr_data
);

   localparam int CW = fc2mfm_pkg::CountWidth;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_code_ff, in_code_in;
   logic                  in_first_ff, in_first_in;
   logic                  in_last_ff, in_last_in;

   // Track state.
   logic [6:0]            pend_bits_ff, pend_bits_in;
   logic [2:0]            pend_cnt_ff, pend_cnt_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  finished_ff, finished_in;
   logic [CW-1:0]         limit_ff, limit_in;

   // Result buffer; slot 0 is the head.
   fc2mfm_pkg::rsp_type   slot_ff [2];
   fc2mfm_pkg::rsp_type   slot_in [2];
   logic [1:0]            occ_ff, occ_in;

   logic                  pop, fire;
   logic [6:0]            pend_eff;
   logic [2:0]            cnt_eff;
   logic [CW-1:0]         count_eff;
   logic                  finished_eff;
   logic [22:0]           stream;
   logic [4:0]            total;
   logic                  term;
   logic [1:0]            nav, nb, nres;
   logic [7:0]            byte0, byte1;
   logic [CW-1:0]         cnt1, cnt2;
   logic                  hit1, hit2, ended;
   logic [2:0]            rem_cnt;
   logic [6:0]            rem_bits;
   fc2mfm_pkg::rsp_type   res0, res1;

   assign pop  = (occ_ff != 2'd0) && rsp_tready;
   // A beat is expanded only when the buffer will be empty after this cycle.
   assign fire = in_valid_ff && ((occ_ff == 2'd0) || ((occ_ff == 2'd1) && rsp_tready));
   assign req_tready = !in_valid_ff || fire;

   assign pend_eff     = in_first_ff ? 7'd0 : pend_bits_ff;
   assign cnt_eff      = in_first_ff ? 3'd0 : pend_cnt_ff;
   assign count_eff    = in_first_ff ? '0 : count_ff;
   assign finished_eff = finished_ff && !in_first_ff;

   // Append the interval bits up to the first terminator, pending bits first.
   always_comb begin
      logic [1:0] code;
      logic [2:0] len;
      stream = {16'd0, pend_eff};
      total  = {2'd0, cnt_eff};
      term   = 1'b0;
      for (int i = 0; i < 4; i++) begin
         code = 2'(in_code_ff >> (6 - 2 * i));
         len  = {1'b0, code} + 3'd1;
         if (!term) begin
            if (code == fc2mfm_pkg::CODE_END) begin
               term = 1'b1;
            end else begin
               stream = (stream << len) | 23'd1;
               total  = total + 5'(len);
            end
         end
      end
   end

   assign nav   = total[4:3];
   assign byte0 = 8'(stream >> (total - 5'd8));
   assign byte1 = 8'(stream >> (total - 5'd16));
   assign cnt1  = count_eff + 14'd1;
   assign cnt2  = count_eff + 14'd2;
   // Reaching the limit on the first byte drops everything after it.
   assign hit1  = (nav != 2'd0) && (cnt1 >= limit_ff);
   assign hit2  = (nav == 2'd2) && !hit1 && (cnt2 >= limit_ff);
   assign nb    = hit1 ? 2'd1 : nav;
   assign ended = term || in_last_ff || hit1 || hit2;

   assign rem_cnt  = total[2:0];
   assign rem_bits = stream[6:0] & 7'((8'd1 << rem_cnt) - 8'd1);

   always_comb begin
      if (finished_eff) begin
         nres = 2'd0;
      end else if (nb == 2'd0) begin
         nres = ended ? 2'd1 : 2'd0;
      end else begin
         nres = nb;
      end
   end

   always_comb begin
      if (nb == 2'd0) begin
         res0.data_byte    = 8'd0;
         res0.byte_valid   = 1'b0;
         res0.last_of_item = 1'b1;
         res0.track_done   = 1'b1;
         res0.byte_count   = count_eff;
      end else begin
         res0.data_byte    = byte0;
         res0.byte_valid   = 1'b1;
         res0.last_of_item = (nb == 2'd1);
         res0.track_done   = (nb == 2'd1) && ended;
         res0.byte_count   = cnt1;
      end
      res1.data_byte    = byte1;
      res1.byte_valid   = 1'b1;
      res1.last_of_item = 1'b1;
      res1.track_done   = ended;
      res1.byte_count   = cnt2;
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_code_in   = in_code_ff;
      in_first_in  = in_first_ff;
      in_last_in   = in_last_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      count_in     = count_ff;
      finished_in  = finished_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      slot_in      = slot_ff;
      occ_in       = occ_ff;

      if (fire) begin
         in_valid_in = 1'b0;
         pend_bits_in = pend_eff;
         pend_cnt_in  = cnt_eff;
         count_in     = count_eff;
         finished_in  = finished_eff;
         if (!finished_eff) begin
            pend_bits_in = ended ? 7'd0 : rem_bits;
            pend_cnt_in  = ended ? 3'd0 : rem_cnt;
            count_in     = count_eff + 14'(nb);
            finished_in  = ended;
         end
         slot_in[0] = res0;
         slot_in[1] = res1;
         occ_in     = nres;
      end else if (pop) begin
         slot_in[0] = slot_ff[1];
         occ_in     = occ_ff - 2'd1;
      end

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_code_in  = req_tdata;
         in_first_in = req_tuser;
         in_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pend_bits_ff <= 7'd0;
         pend_cnt_ff  <= 3'd0;
         count_ff     <= '0;
         finished_ff  <= 1'b0;
         limit_ff     <= fc2mfm_pkg::LIMIT_RESET;
         occ_ff       <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         limit_ff     <= limit_in;
         occ_ff       <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      in_code_ff  <= in_code_in;
      in_first_ff <= in_first_in;
      in_last_ff  <= in_last_in;
      slot_ff     <= slot_in;
   end

   assign rsp_tvalid = (occ_ff != 2'd0);
   assign rsp_tdata  = {2'd0, slot_ff[0].byte_count, slot_ff[0].data_byte};
   assign rsp_tuser  = {slot_ff[0].track_done, slot_ff[0].byte_valid};
   assign rsp_tlast  = slot_ff[0].last_of_item;

   `FC2MFM_ASSERT_IMP(a_fire_into_empty, clock, reset, fire,
      (occ_ff == 2'd0) || ((occ_ff == 2'd1) && rsp_tready))
   `FC2MFM_ASSERT_NXT(a_pair_follows, clock, reset, fire && (nres == 2'd2),
      rsp_tvalid && !rsp_tlast && (occ_ff == 2'd2))
   `FC2MFM_ASSERT_IMP(a_partial_has_partner, clock, reset, rsp_tvalid && !rsp_tlast,
      occ_ff == 2'd2)
   `FC2MFM_ASSERT_IMP(a_finished_silent, clock, reset, fire && finished_eff,
      nres == 2'd0)
   `FC2MFM_ASSERT_IMP(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser[1],
      rsp_tlast)

endmodule
